FILE: src/wire_chamber_word_decoder_macros.svh
// Assertion macros for the wire chamber word decoder.
`ifndef WIRE_CHAMBER_WORD_DECODER_MACROS_SVH
`define WIRE_CHAMBER_WORD_DECODER_MACROS_SVH

// Clocked check, disabled while reset is high.
`define WCWD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds through reset.
`define WCWD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/wcwd_pkg.sv
// Types and constants shared by the wire chamber word decoder modules.
package wcwd_pkg;

   localparam int NUM_CHAMBERS = 6;
   localparam int CODE_W       = 4;
   localparam int IDX_W        = 3;
   localparam int CNT_W        = 7;
   localparam int SLOT_W       = 6;
   localparam int WIDTH_W      = 4;
   localparam int CHAN_W       = 10;
   localparam int WORD_W       = 16;
   localparam int SIZE_W       = 13;
   localparam int CSR_IDX_W    = 3;

   localparam logic [WIDTH_W-1:0] WIDTH_NONE = 4'd1;

   typedef enum logic [1:0] {
      OP_READOUT = 2'd0,
      OP_HEADER  = 2'd1,
      OP_CLEAR   = 2'd2
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CODE_X1    = 3'd0,
      CSR_CODE_X2    = 3'd1,
      CSR_CODE_U3    = 3'd2,
      CSR_CODE_V3    = 3'd3,
      CSR_CODE_U4    = 3'd4,
      CSR_CODE_V4    = 3'd5,
      CSR_CODE_DUMMY = 3'd6
   } csr_idx_type;

   typedef logic [CODE_W-1:0] code_arr_type [NUM_CHAMBERS];
   typedef logic [CNT_W-1:0]  cnt_arr_type  [NUM_CHAMBERS];

   typedef struct packed {
      logic                hit_valid;
      logic [IDX_W-1:0]    chamber_index;
      logic [SLOT_W-1:0]   hit_slot;
      logic [CHAN_W-1:0]   wire_channel;
      logic [WIDTH_W-1:0]  cluster_width;
      logic                half_bit;
      logic                halfbit_error;
      logic                missing_channel;
      logic                bad_chamber;
      logic                count_mismatch;
      logic                overflow;
   } rsp_type;

   typedef struct packed {
      logic                pw_we;
      logic [WIDTH_W-1:0]  pw;
      logic                cnt_we;
      logic [IDX_W-1:0]    cnt_idx;
      logic                clear;
   } upd_type;

endpackage

FILE: src/wire_chamber_word_decoder.sv
// Top level of the wire chamber word decoder.
//
// Channels: req_* carries one item per beat (op, data_word, region_size);
// rsp_* returns exactly one result beat per item, in order. Both use
// valid/stall; a beat moves when valid is high and stall is low.
// csr_* writes the seven chamber code registers, one per cycle; the user must
// write them only while idle (the block does not enforce it). Items pass the
// input register, then decode into the result register. Throughput: one item
// per cycle while rsp_stall is low, set by the single decode pass between them.
// Stall: while rsp_stall holds a waiting result, the input register still
// takes one more item; once it is full, req_stall rises until the result
// beat moves.
// Reset: synchronous, active high; clears both pipeline stages, sets the
// pending width to one, zeroes the per-chamber hit counts and loads the
// default chamber codes (planes 0..5, dummy 6).
module wire_chamber_word_decoder #(
   parameter int unsigned MAX_HITS = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [1:0]   req_op,
   input  logic [15:0]  req_data_word,
   input  logic [12:0]  req_region_size,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic         rsp_hit_valid,
   output logic [2:0]   rsp_chamber_index,
   output logic [5:0]   rsp_hit_slot,
   output logic [9:0]   rsp_wire_channel,
   output logic [3:0]   rsp_cluster_width,
   output logic         rsp_half_bit,
   output logic         rsp_halfbit_error,
   output logic         rsp_missing_channel,
   output logic         rsp_bad_chamber,
   output logic         rsp_count_mismatch,
   output logic         rsp_overflow,
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [3:0]   csr_wdata
);

   `include "wire_chamber_word_decoder_macros.svh"

   wcwd_pkg::code_arr_type                codes;
   logic [wcwd_pkg::CODE_W-1:0]           code_dummy;

   logic                                  in_valid_ff;
   logic [1:0]                            in_op_ff;
   logic [wcwd_pkg::WORD_W-1:0]           in_word_ff;
   logic [wcwd_pkg::SIZE_W-1:0]           in_size_ff;

   logic                                  rsp_valid_ff;
   wcwd_pkg::rsp_type                     rsp_ff;
   wcwd_pkg::rsp_type                     rsp_in;
   wcwd_pkg::upd_type                     upd;

   logic [wcwd_pkg::WIDTH_W-1:0]          pw_ff;
   logic [wcwd_pkg::WIDTH_W-1:0]          pw_in;
   wcwd_pkg::cnt_arr_type                 counts_ff;
   wcwd_pkg::cnt_arr_type                 counts_in;

   logic                                  advance;
   logic                                  in_load;
   logic                                  apply;

   wcwd_cfg u_cfg (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .codes      (codes),
      .code_dummy (code_dummy)
   );

   wcwd_decode #(
      .MAX_HITS (MAX_HITS)
   ) u_decode (
      .op            (in_op_ff),
      .data_word     (in_word_ff),
      .region_size   (in_size_ff),
      .codes         (codes),
      .code_dummy    (code_dummy),
      .pending_width (pw_ff),
      .hit_counts    (counts_ff),
      .rsp           (rsp_in),
      .upd           (upd)
   );

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;
   assign in_load   = !req_stall;
   assign apply     = advance && in_valid_ff;

   always_comb begin
      pw_in     = pw_ff;
      counts_in = counts_ff;
      if (apply) begin
         if (upd.pw_we) begin
            pw_in = upd.pw;
         end
         if (upd.clear) begin
            for (int i = 0; i < wcwd_pkg::NUM_CHAMBERS; i++) begin
               counts_in[i] = '0;
            end
         end else if (upd.cnt_we) begin
            counts_in[upd.cnt_idx] = counts_ff[upd.cnt_idx] + 7'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pw_ff        <= wcwd_pkg::WIDTH_NONE;
         for (int i = 0; i < wcwd_pkg::NUM_CHAMBERS; i++) begin
            counts_ff[i] <= '0;
         end
      end else begin
         if (in_load) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= in_valid_ff;
         end
         pw_ff     <= pw_in;
         counts_ff <= counts_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load && req_valid) begin
         in_op_ff   <= req_op;
         in_word_ff <= req_data_word;
         in_size_ff <= req_region_size;
      end
      if (apply) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_hit_valid       = rsp_ff.hit_valid;
   assign rsp_chamber_index   = rsp_ff.chamber_index;
   assign rsp_hit_slot        = rsp_ff.hit_slot;
   assign rsp_wire_channel    = rsp_ff.wire_channel;
   assign rsp_cluster_width   = rsp_ff.cluster_width;
   assign rsp_half_bit        = rsp_ff.half_bit;
   assign rsp_halfbit_error   = rsp_ff.halfbit_error;
   assign rsp_missing_channel = rsp_ff.missing_channel;
   assign rsp_bad_chamber     = rsp_ff.bad_chamber;
   assign rsp_count_mismatch  = rsp_ff.count_mismatch;
   assign rsp_overflow        = rsp_ff.overflow;

   `WCWD_ASSERT(a_hit_excl, clock, reset, rsp_valid && rsp_hit_valid |-> !rsp_overflow && !rsp_bad_chamber && !rsp_count_mismatch, "stored hit reported with an error flag")
   `WCWD_ASSERT(a_stall_full, clock, reset, req_stall |-> in_valid_ff && rsp_valid_ff, "request stalled with room in the pipeline")
   `WCWD_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid && !req_stall, "pipeline not empty after reset")

endmodule

FILE: src/wcwd_cfg.sv
// Chamber code registers written through the configuration port.
module wcwd_cfg (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_we,
   input  logic [wcwd_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [wcwd_pkg::CODE_W-1:0]            csr_wdata,
   output wcwd_pkg::code_arr_type                 codes,
   output logic [wcwd_pkg::CODE_W-1:0]            code_dummy
);

   wcwd_pkg::code_arr_type              codes_ff;
   logic [wcwd_pkg::CODE_W-1:0]         dummy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < wcwd_pkg::NUM_CHAMBERS; i++) begin
            codes_ff[i] <= wcwd_pkg::CODE_W'(i);
         end
         dummy_ff <= wcwd_pkg::CODE_W'(wcwd_pkg::NUM_CHAMBERS);
      end else if (csr_we) begin
         unique case (csr_index)
            wcwd_pkg::CSR_CODE_X1:    codes_ff[0] <= csr_wdata;
            wcwd_pkg::CSR_CODE_X2:    codes_ff[1] <= csr_wdata;
            wcwd_pkg::CSR_CODE_U3:    codes_ff[2] <= csr_wdata;
            wcwd_pkg::CSR_CODE_V3:    codes_ff[3] <= csr_wdata;
            wcwd_pkg::CSR_CODE_U4:    codes_ff[4] <= csr_wdata;
            wcwd_pkg::CSR_CODE_V4:    codes_ff[5] <= csr_wdata;
            wcwd_pkg::CSR_CODE_DUMMY: dummy_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign codes      = codes_ff;
   assign code_dummy = dummy_ff;

endmodule

FILE: src/wcwd_decode.sv
// Combinational decode of one item against the current decoder state.
module wcwd_decode #(
   parameter int unsigned MAX_HITS = 64
) (
   input  logic [1:0]                          op,
   input  logic [wcwd_pkg::WORD_W-1:0]         data_word,
   input  logic [wcwd_pkg::SIZE_W-1:0]         region_size,
   input  wcwd_pkg::code_arr_type              codes,
   input  logic [wcwd_pkg::CODE_W-1:0]         code_dummy,
   input  logic [wcwd_pkg::WIDTH_W-1:0]        pending_width,
   input  wcwd_pkg::cnt_arr_type               hit_counts,
   output wcwd_pkg::rsp_type                   rsp,
   output wcwd_pkg::upd_type                   upd
);

   logic [wcwd_pkg::CODE_W-1:0]  code;
   logic                         match;
   logic [wcwd_pkg::IDX_W-1:0]   idx;
   logic [wcwd_pkg::CNT_W-1:0]   cnt_sel;
   logic                         pending;

   assign code    = data_word[14:11];
   assign pending = (pending_width != wcwd_pkg::WIDTH_NONE);

   always_comb begin
      match = 1'b0;
      idx   = '0;
      for (int i = wcwd_pkg::NUM_CHAMBERS - 1; i >= 0; i--) begin
         if (codes[i] == code) begin
            match = 1'b1;
            idx   = wcwd_pkg::IDX_W'(i);
         end
      end
   end

   assign cnt_sel = hit_counts[idx];

   always_comb begin
      rsp = '0;
      upd = '0;
      case (op)
         wcwd_pkg::OP_READOUT: begin
            upd.pw_we = 1'b1;
            upd.pw    = wcwd_pkg::WIDTH_NONE;
            if (data_word[15:14] == 2'b11) begin
               rsp.missing_channel = pending;
            end else if (data_word[15]) begin
               rsp.missing_channel = pending;
               upd.pw              = data_word[3:0];
            end else if (match) begin
               rsp.chamber_index = idx;
               rsp.wire_channel  = {data_word[10:6], data_word[5:1]};
               rsp.cluster_width = pending_width;
               rsp.half_bit      = data_word[0];
               rsp.halfbit_error = (data_word[0] == pending_width[0]);
               if (cnt_sel >= wcwd_pkg::CNT_W'(MAX_HITS)) begin
                  rsp.overflow = 1'b1;
               end else begin
                  rsp.hit_valid = 1'b1;
                  rsp.hit_slot  = cnt_sel[wcwd_pkg::SLOT_W-1:0];
                  upd.cnt_we    = 1'b1;
                  upd.cnt_idx   = idx;
               end
            end else if (!(code == code_dummy && (|data_word[10:2]))) begin
               rsp.bad_chamber = 1'b1;
            end
         end
         wcwd_pkg::OP_HEADER: begin
            rsp.count_mismatch = ({1'b0, data_word[11:0]} != (region_size - 13'd1));
            upd.pw_we          = 1'b1;
            upd.pw             = wcwd_pkg::WIDTH_NONE;
         end
         wcwd_pkg::OP_CLEAR: begin
            upd.clear = 1'b1;
         end
         default: ;
      endcase
   end

endmodule
